// ===== rtl/core/mxyrt_pkg.sv =====
// Package for the mesh XY route table generator: sequencer codes, the
// control word type and the microcode store. No dependencies.
package mxyrt_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_COLUMN_COUNT      = 2'd0;
  localparam logic [1:0] REG_ROW_COUNT         = 2'd1;
  localparam logic [1:0] REG_SINGLE_CONTROLLER = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [6:0] COLUMN_COUNT_RST = 7'd8;
  localparam logic [6:0] ROW_COUNT_RST    = 7'd10;

  // One quotient bit per step over the six source index bits.
  localparam int unsigned DIV_STEPS = 6;

  // Route codes.
  localparam logic [1:0] ROUTE_NORTH = 2'd0;
  localparam logic [1:0] ROUTE_EAST  = 2'd1;
  localparam logic [1:0] ROUTE_SOUTH = 2'd2;
  localparam logic [1:0] ROUTE_WEST  = 2'd3;

  typedef logic [2:0] pc_t;

  typedef enum logic [1:0] {
    OP_WAIT,
    OP_DIV,
    OP_FLAG,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_NO_ACCEPT,
    COND_DIV_MORE,
    COND_EMIT_MORE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ctrl_word_t;

  localparam pc_t PC_WAIT = 3'd0;
  localparam pc_t PC_DIV  = 3'd1;
  localparam pc_t PC_FLAG = 3'd2;
  localparam pc_t PC_EMIT = 3'd3;
  localparam pc_t PC_DONE = 3'd4;

  // Microcode store. The jump is taken when the condition holds, else the
  // step counter advances by one.
  function automatic ctrl_word_t ucode(input pc_t pc);
    ctrl_word_t w;
    unique case (pc)
      PC_WAIT: w = '{op: OP_WAIT, cond: COND_NO_ACCEPT, target: PC_WAIT};
      PC_DIV:  w = '{op: OP_DIV,  cond: COND_DIV_MORE,  target: PC_DIV};
      PC_FLAG: w = '{op: OP_FLAG, cond: COND_NEXT,      target: PC_WAIT};
      PC_EMIT: w = '{op: OP_EMIT, cond: COND_EMIT_MORE, target: PC_EMIT};
      PC_DONE: w = '{op: OP_FLAG, cond: COND_ALWAYS,    target: PC_WAIT};
      default: w = '{op: OP_WAIT, cond: COND_ALWAYS,    target: PC_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/mesh_xy_route_table_gen.sv =====
// Top level of the mesh XY route table generator: microcoded sequencer,
// source divider and four-destination route datapath. Depends on mxyrt_pkg.
//
// Usage: each input beat on the in_ channel carries one source node index.
// For it the block emits (TABLE_NODES+3)/4 output beats, each packing the
// next hop toward four consecutive destinations, destination k of a beat at
// bits 2k+1:2k (0 north, 1 east, 2 south, 3 west). The final beat of a
// source carries last_of_source, and also last_of_table when the source is
// node TABLE_NODES-1. The cfg_ port writes column_count, row_count and
// single_controller; write them only while the block is idle.
// Timing: the accepting step, six divide steps that split the source index
// into row and column, and one flag step come before the first beat, which
// is registered. Beats then follow one per cycle while the receiver does not
// stall, and one closing step returns to the accepting step. in_stall is low
// only in the accepting step. A stall on the output holds the beat and pauses
// the sequencer in its emit step. Reset returns the sequencer to the
// accepting step, empties the output register and loads the register reset
// values (8 columns, 10 rows).
module mesh_xy_route_table_gen #(
  parameter int TABLE_NODES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [5:0] in_source_node,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_route_byte,
  output logic       out_last_of_source,
  output logic       out_last_of_table,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_wdata
);

  localparam int NBYTES = (TABLE_NODES + 3) / 4;
  localparam int BW     = (NBYTES > 1) ? $clog2(NBYTES) : 1;
  localparam int NW     = $clog2(TABLE_NODES);
  // Destination row width; it must also hold any source row.
  localparam int RW     = (NW > 6) ? NW : 6;

  // Configuration registers.
  logic [6:0] column_count_r, row_count_r;
  logic       single_controller_r;

  // Sequencer.
  mxyrt_pkg::pc_t        pc_r, pc_nxt;
  mxyrt_pkg::ctrl_word_t ctrl;
  logic                  jump;

  // Divider and source state.
  logic [5:0] src_r, dvd_r, quo_r;
  logic [6:0] rem_r;
  logic [2:0] cnt_r;
  logic       ew_ok_r;

  // Destination walk.
  logic [6:0]    dcol_r;
  logic [RW-1:0] drow_r;
  logic [BW-1:0] b_r;

  // Output register.
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_los_r, out_lot_r;

  logic [6:0] cols;
  logic [7:0] trial;
  logic [6:0] trial_sub;
  logic       trial_ge;
  logic       load, last_byte, bottom, src_is_last;
  logic [7:0] byte_w;
  logic [6:0] col_w [5];
  logic [RW-1:0] row_w [5];
  logic [1:0] route_w [4];

  // A zero column count acts as one column.
  assign cols = (column_count_r == 7'd0) ? 7'd1 : column_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r      <= mxyrt_pkg::COLUMN_COUNT_RST;
      row_count_r         <= mxyrt_pkg::ROW_COUNT_RST;
      single_controller_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        mxyrt_pkg::REG_COLUMN_COUNT:      column_count_r      <= cfg_wdata;
        mxyrt_pkg::REG_ROW_COUNT:         row_count_r         <= cfg_wdata;
        mxyrt_pkg::REG_SINGLE_CONTROLLER: single_controller_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign ctrl      = mxyrt_pkg::ucode(pc_r);
  assign in_stall  = (ctrl.op != mxyrt_pkg::OP_WAIT);
  assign last_byte = (b_r == BW'(NBYTES - 1));
  // In the emit step the output register takes a beat when it is empty or being drained.
  assign load      = (ctrl.op == mxyrt_pkg::OP_EMIT) && (!out_valid_r || !out_stall);

  // Restoring division, one quotient bit per step. The remainder after a
  // subtraction is below the column count, so seven bits hold it.
  assign trial     = {rem_r, dvd_r[5]};
  assign trial_sub = trial[6:0] - cols;
  assign trial_ge  = (trial >= {1'b0, cols});

  // A zero row count has no bottom row.
  assign bottom = (row_count_r != 7'd0) && ({1'b0, quo_r} == row_count_r - 7'd1);
  assign src_is_last = ({3'b000, src_r} == 9'(TABLE_NODES - 1));

  // Next step of the sequencer.
  always_comb begin
    unique case (ctrl.cond)
      mxyrt_pkg::COND_NEXT:      jump = 1'b0;
      mxyrt_pkg::COND_ALWAYS:    jump = 1'b1;
      mxyrt_pkg::COND_NO_ACCEPT: jump = !in_valid;
      mxyrt_pkg::COND_DIV_MORE:  jump = (cnt_r != 3'(mxyrt_pkg::DIV_STEPS - 1));
      mxyrt_pkg::COND_EMIT_MORE: jump = !(load && last_byte);
      default:                   jump = 1'b1;
    endcase
    pc_nxt = jump ? ctrl.target : pc_r + 3'd1;
  end

  // Four destinations per beat: walk the column counter, wrapping into the
  // next row when it reaches the column count.
  always_comb begin
    col_w[0] = dcol_r;
    row_w[0] = drow_r;
    byte_w   = 8'h00;
    for (int k = 0; k < 4; k++) begin
      if (ew_ok_r && (col_w[k] < rem_r)) begin
        route_w[k] = mxyrt_pkg::ROUTE_WEST;
      end else if (ew_ok_r && (col_w[k] > rem_r)) begin
        route_w[k] = mxyrt_pkg::ROUTE_EAST;
      end else if (row_w[k] > RW'(quo_r)) begin
        route_w[k] = mxyrt_pkg::ROUTE_SOUTH;
      end else begin
        route_w[k] = mxyrt_pkg::ROUTE_NORTH;
      end
      // Destinations past the table leave their bits at zero.
      if ({1'b0, b_r, 2'(k)} < (BW + 3)'(TABLE_NODES)) begin
        byte_w[2*k +: 2] = route_w[k];
      end
      if (({1'b0, col_w[k]} + 8'd1) == {1'b0, cols}) begin
        col_w[k+1] = 7'd0;
        row_w[k+1] = row_w[k] + RW'(1);
      end else begin
        col_w[k+1] = col_w[k] + 7'd1;
        row_w[k+1] = row_w[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= mxyrt_pkg::PC_WAIT;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= load || (out_valid_r && out_stall);
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (ctrl.op)
      mxyrt_pkg::OP_WAIT: begin
        src_r <= in_source_node;
        dvd_r <= in_source_node;
        rem_r <= 7'd0;
        quo_r <= 6'd0;
        cnt_r <= 3'd0;
      end
      mxyrt_pkg::OP_DIV: begin
        dvd_r <= {dvd_r[4:0], 1'b0};
        quo_r <= {quo_r[4:0], trial_ge};
        rem_r <= trial_ge ? trial_sub : trial[6:0];
        cnt_r <= cnt_r + 3'd1;
      end
      mxyrt_pkg::OP_FLAG: begin
        ew_ok_r <= (quo_r != 6'd0) && (!bottom || single_controller_r);
        dcol_r  <= 7'd0;
        drow_r  <= '0;
        b_r     <= '0;
      end
      mxyrt_pkg::OP_EMIT: begin
        if (load) begin
          dcol_r <= col_w[4];
          drow_r <= row_w[4];
          b_r    <= b_r + BW'(1);
        end
      end
      default: ;
    endcase
    if (load) begin
      out_byte_r <= byte_w;
      out_los_r  <= last_byte;
      out_lot_r  <= last_byte && src_is_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_route_byte     = out_byte_r;
  assign out_last_of_source = out_los_r;
  assign out_last_of_table  = out_lot_r;

endmodule

// ===== rtl/core/mxyrt_checker.sv =====
// Port-level checker for the mesh XY route table generator and its bind.
// Depends on mesh_xy_route_table_gen.
module mxyrt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_route_byte,
  input logic       out_last_of_source,
  input logic       out_last_of_table
);

  // A stalled output beat holds its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_route_byte)
      && $stable(out_last_of_source) && $stable(out_last_of_table))
    else $error("stalled output beat changed");

  // Once a source is taken the block is busy with its table.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

  // The end of the table is always the end of a source.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_table |-> out_last_of_source)
    else $error("last_of_table without last_of_source");

  // Reset empties the output register.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output beat present after reset");

endmodule

bind mesh_xy_route_table_gen mxyrt_checker u_mxyrt_checker (.*);
